/* src/scr_pkg.sv */
// Shared codes, types and constants for the scatter-reduce store.
package scr_pkg;

   localparam int STORE_DEPTH_DEFAULT = 4096;

   // pipeline depths of the address and combine units
   localparam int ADDR_LATENCY = 3;
   localparam int FPU_LATENCY  = 5;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_SCATTER = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;

   localparam logic [2:0] MODE_ASSIGN = 3'd0;
   localparam logic [2:0] MODE_ADD    = 3'd1;
   localparam logic [2:0] MODE_MUL    = 3'd2;
   localparam logic [2:0] MODE_MAX    = 3'd3;
   localparam logic [2:0] MODE_MIN    = 3'd4;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_SKIP   = 2'd1;
   localparam logic [1:0] STAT_BEYOND = 2'd2;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_DIM   = 2'd1;
   localparam logic [1:0] CSR_INNER = 2'd2;

   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

   typedef struct packed {
      logic        pos_bad;
      logic [39:0] addr;
   } addr_result_type;

endpackage

/* src/scr_addr.sv */
// Address generator: (outer*dim_size + position)*inner_size + inner, three stages.
module scr_addr import scr_pkg::*; (
   input  logic               clock,
   input  logic [11:0]        outer_coord,
   input  logic signed [15:0] position,
   input  logic [11:0]        inner_coord,
   input  logic [12:0]        dim_size,
   input  logic [12:0]        inner_size,
   output addr_result_type    result
);

   logic [24:0] prod1_ff, prod1_in;
   logic [12:0] pos1_ff;
   logic        bad1_ff, bad1_in;
   logic [11:0] inner1_ff;

   logic [25:0] base;
   logic [38:0] prod2_ff, prod2_in;
   logic        bad2_ff;
   logic [11:0] inner2_ff;

   logic [39:0] addr_ff, addr_in;
   logic        bad3_ff;

   assign prod1_in = {13'b0, outer_coord} * {12'b0, dim_size};
   // negative positions fail through the sign bit
   assign bad1_in  = position[15] | ({3'b0, position[12:0]} >= {3'b0, dim_size})
                     | (position[14:13] != 2'b00);

   assign base     = {1'b0, prod1_ff} + {13'b0, pos1_ff};
   assign prod2_in = {13'b0, base} * {26'b0, inner_size};
   assign addr_in  = {1'b0, prod2_ff} + {28'b0, inner2_ff};

   always_ff @(posedge clock) begin
      prod1_ff  <= prod1_in;
      pos1_ff   <= position[12:0];
      bad1_ff   <= bad1_in;
      inner1_ff <= inner_coord;
      prod2_ff  <= prod2_in;
      bad2_ff   <= bad1_ff;
      inner2_ff <= inner1_ff;
      addr_ff   <= addr_in;
      bad3_ff   <= bad2_ff;
   end

   assign result.pos_bad = bad3_ff;
   assign result.addr    = addr_ff;

endmodule

/* src/scr_fpu.sv */
// Combine unit: fp32 assign, add, multiply, max and min in five stages.
module scr_fpu import scr_pkg::*; (
   input  logic        clock,
   input  logic [2:0]  mode,
   input  logic [31:0] d_bits,
   input  logic [31:0] s_bits,
   output logic [31:0] r_bits
);

   function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic res;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
      if (a_nan || b_nan) begin
         res = 1'b0;
      end else if ((a[30:0] == 31'b0) && (b[30:0] == 31'b0)) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (!a[31]) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction

   function automatic logic [5:0] lead_zeros(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // ---- stage 1: unpack, special cases, alignment
   logic        d_nan, s_nan, d_inf, s_inf, d_zero, s_zero;
   logic [23:0] d_m, s_m, a_m, b_m;
   logic [7:0]  d_e, s_e, a_e, b_e, diff;
   logic        a_sg, b_sg, d_big;
   logic [4:0]  dsh;
   logic [53:0] b_shift;
   logic [26:0] b_aligned;
   logic        is_mul;
   logic        spec_in;
   logic [31:0] specval_in;
   logic [9:0]  e0_in;
   logic        sign_in;
   logic [26:0] op_a_in, op_b_in;

   logic        spec1_ff, mul1_ff, sub1_ff, sign1_ff;
   logic [31:0] specval1_ff;
   logic [9:0]  e01_ff;
   logic [26:0] op_a1_ff, op_b1_ff;

   assign d_nan  = (d_bits[30:23] == 8'hFF) && (d_bits[22:0] != 23'b0);
   assign s_nan  = (s_bits[30:23] == 8'hFF) && (s_bits[22:0] != 23'b0);
   assign d_inf  = (d_bits[30:23] == 8'hFF) && (d_bits[22:0] == 23'b0);
   assign s_inf  = (s_bits[30:23] == 8'hFF) && (s_bits[22:0] == 23'b0);
   assign d_zero = d_bits[30:0] == 31'b0;
   assign s_zero = s_bits[30:0] == 31'b0;
   assign d_m    = {d_bits[30:23] != 8'h00, d_bits[22:0]};
   assign s_m    = {s_bits[30:23] != 8'h00, s_bits[22:0]};
   assign d_e    = (d_bits[30:23] == 8'h00) ? 8'd1 : d_bits[30:23];
   assign s_e    = (s_bits[30:23] == 8'h00) ? 8'd1 : s_bits[30:23];

   assign d_big  = d_bits[30:0] >= s_bits[30:0];
   assign a_m    = d_big ? d_m : s_m;
   assign b_m    = d_big ? s_m : d_m;
   assign a_e    = d_big ? d_e : s_e;
   assign b_e    = d_big ? s_e : d_e;
   assign a_sg   = d_big ? d_bits[31] : s_bits[31];
   assign b_sg   = d_big ? s_bits[31] : d_bits[31];
   assign diff   = a_e - b_e;
   assign dsh    = (diff > 8'd27) ? 5'd27 : diff[4:0];
   assign b_shift   = {b_m, 3'b0, 27'b0} >> dsh;
   assign b_aligned = {b_shift[53:28], b_shift[27] | (b_shift[26:0] != 27'b0)};

   assign is_mul = mode == MODE_MUL;

   always_comb begin
      spec_in    = 1'b1;
      specval_in = s_bits;
      case (mode)
         MODE_ADD: begin
            if (d_nan) begin
               specval_in = d_bits | 32'h0040_0000;
            end else if (s_nan) begin
               specval_in = s_bits | 32'h0040_0000;
            end else if (d_inf && s_inf && (d_bits[31] != s_bits[31])) begin
               specval_in = FP_DEFAULT_NAN;
            end else if (d_inf) begin
               specval_in = d_bits;
            end else if (s_inf) begin
               specval_in = s_bits;
            end else begin
               spec_in = 1'b0;
            end
         end
         MODE_MUL: begin
            if (d_nan) begin
               specval_in = d_bits | 32'h0040_0000;
            end else if (s_nan) begin
               specval_in = s_bits | 32'h0040_0000;
            end else if ((d_inf && s_zero) || (s_inf && d_zero)) begin
               specval_in = FP_DEFAULT_NAN;
            end else if (d_inf || s_inf) begin
               specval_in = {d_bits[31] ^ s_bits[31], 8'hFF, 23'b0};
            end else begin
               spec_in = 1'b0;
            end
         end
         MODE_MAX: specval_in = fp_lt(d_bits, s_bits) ? s_bits : d_bits;
         MODE_MIN: specval_in = fp_lt(s_bits, d_bits) ? s_bits : d_bits;
         default:  specval_in = s_bits;
      endcase
   end

   assign e0_in   = is_mul ? ({2'b0, d_e} + {2'b0, s_e} - 10'd126) : ({2'b0, a_e} + 10'd1);
   assign sign_in = is_mul ? (d_bits[31] ^ s_bits[31]) : a_sg;
   assign op_a_in = is_mul ? {3'b0, d_m} : {a_m, 3'b0};
   assign op_b_in = is_mul ? {3'b0, s_m} : b_aligned;

   always_ff @(posedge clock) begin
      spec1_ff    <= spec_in;
      specval1_ff <= specval_in;
      mul1_ff     <= is_mul;
      sub1_ff     <= a_sg ^ b_sg;
      sign1_ff    <= sign_in;
      e01_ff      <= e0_in;
      op_a1_ff    <= op_a_in;
      op_b1_ff    <= op_b_in;
   end

   // ---- stage 2: add/subtract or multiply
   logic [27:0] sum28;
   logic [47:0] m2_in;
   logic        sign2_in;
   logic [47:0] m2_ff;
   logic [9:0]  e02_ff;
   logic        sign2_ff, spec2_ff;
   logic [31:0] specval2_ff;

   assign sum28 = sub1_ff ? ({1'b0, op_a1_ff} - {1'b0, op_b1_ff})
                          : ({1'b0, op_a1_ff} + {1'b0, op_b1_ff});
   assign m2_in = mul1_ff ? (op_a1_ff[23:0] * op_b1_ff[23:0]) : {sum28, 20'b0};
   // exact cancellation rounds to +0
   assign sign2_in = (!mul1_ff && sub1_ff && (sum28 == 28'b0)) ? 1'b0 : sign1_ff;

   always_ff @(posedge clock) begin
      m2_ff       <= m2_in;
      e02_ff      <= e01_ff;
      sign2_ff    <= sign2_in;
      spec2_ff    <= spec1_ff;
      specval2_ff <= specval1_ff;
   end

   // ---- stage 3: leading-zero count and shift plan
   logic [5:0]  lz;
   logic [9:0]  lim, ls, rs;
   logic        left_in;
   logic [5:0]  amt_in;
   logic [9:0]  exp3_in;
   logic [47:0] m3_ff;
   logic        left3_ff, sign3_ff, spec3_ff;
   logic [5:0]  amt3_ff;
   logic [9:0]  exp3_ff;
   logic [31:0] specval3_ff;

   assign lz      = lead_zeros(m2_ff);
   assign left_in = !e02_ff[9] && (e02_ff != 10'd0);
   assign lim     = e02_ff - 10'd1;
   assign ls      = ({4'b0, lz} < lim) ? {4'b0, lz} : lim;
   assign rs      = 10'd1 - e02_ff;
   assign amt_in  = left_in ? ls[5:0] : ((rs > 10'd48) ? 6'd48 : rs[5:0]);
   assign exp3_in = left_in ? (e02_ff - ls) : 10'd0;

   always_ff @(posedge clock) begin
      m3_ff       <= m2_ff;
      left3_ff    <= left_in;
      amt3_ff     <= amt_in;
      exp3_ff     <= exp3_in;
      sign3_ff    <= sign2_ff;
      spec3_ff    <= spec2_ff;
      specval3_ff <= specval2_ff;
   end

   // ---- stage 4: normalize and pick rounding increment
   logic [95:0] rsh;
   logic [47:0] n;
   logic        st_r, sticky, ovf_in, inc_in;
   logic [7:0]  efield;
   logic [30:0] packed4_ff;
   logic        inc4_ff, ovf4_ff, sign4_ff, spec4_ff;
   logic [31:0] specval4_ff;

   assign rsh    = {m3_ff, 48'b0} >> amt3_ff;
   assign n      = left3_ff ? (m3_ff << amt3_ff) : rsh[95:48];
   assign st_r   = left3_ff ? 1'b0 : (rsh[47:0] != 48'b0);
   assign sticky = st_r | (n[22:0] != 23'b0);
   assign ovf_in = n[47] && (exp3_ff >= 10'd255);
   assign efield = n[47] ? exp3_ff[7:0] : 8'd0;
   assign inc_in = n[23] & (sticky | n[24]);

   always_ff @(posedge clock) begin
      packed4_ff  <= {efield, n[46:24]};
      inc4_ff     <= inc_in;
      ovf4_ff     <= ovf_in;
      sign4_ff    <= sign3_ff;
      spec4_ff    <= spec3_ff;
      specval4_ff <= specval3_ff;
   end

   // ---- stage 5: round and pack; carry may run into the exponent
   logic [31:0] r_in, r_ff;

   always_comb begin
      if (spec4_ff) begin
         r_in = specval4_ff;
      end else if (ovf4_ff) begin
         r_in = {sign4_ff, 8'hFF, 23'b0};
      end else begin
         r_in = {sign4_ff, packed4_ff + {30'b0, inc4_ff}};
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign r_bits = r_ff;

endmodule

/* src/scr_store.sv */
// Target word store: one write port, one read port with registered data.
module scr_store import scr_pkg::*; #(
   parameter int DEPTH = STORE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/scatter_reduce_store.sv */
// Scatter-reduce store: top level with request sequencer and result register.
//
// Request channel (req_*): one action per request: write a word, scatter-combine
// a source value, or read a word. Accepted when req_valid is high and req_stall
// is low. Result channel (rsp_*): one result per request, read_bits and status,
// taken when rsp_valid is high and rsp_stall is low.
// Configuration (csr_*): reduce mode, dim size and inner size, written by index; the user
// writes them only while no request is in flight (the block does not enforce it); csr_ready is always high.
// One request is worked at a time: address arithmetic (two multiplies), store
// read, the combine pipeline, then write-back. A new request is taken only after
// the previous one has finished, which a stalled result register can hold off.
// A stalled result stays in its register; the sequencer holds the finished
// request until that register frees, so no result is dropped.
// Reset clears the sequencer, the result valid flag and the configuration registers;
// store contents are undefined until written.
module scatter_reduce_store import scr_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [11:0]        req_flat_address,
   input  logic [11:0]        req_outer_coord,
   input  logic signed [15:0] req_position,
   input  logic [11:0]        req_inner_coord,
   input  logic [31:0]        req_value_bits,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_read_bits,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [39:0] DEPTH40 = 40'(STORE_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADDR = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_COMB = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic [2:0]  mode_ff;
   logic [12:0] dim_ff, inner_size_ff;

   logic [1:0]         act_ff;
   logic [11:0]        flat_ff, outer_ff, inner_ff;
   logic signed [15:0] pos_ff;
   logic [31:0]        value_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_bits_ff;
   logic [1:0]         rsp_status_ff;

   addr_result_type    ares;
   logic [39:0]        flat40, sel40;
   logic               flat_ok, addr_ok, accept, finish, wr_en;
   logic [31:0]        rd_data, comb_bits, res_bits;
   logic [1:0]         res_status;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ASSIGN;
         dim_ff        <= 13'd1;
         inner_size_ff <= 13'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:  mode_ff       <= csr_data[2:0];
            CSR_DIM:   dim_ff        <= csr_data;
            CSR_INNER: inner_size_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_action;
         flat_ff  <= req_flat_address;
         outer_ff <= req_outer_coord;
         pos_ff   <= req_position;
         inner_ff <= req_inner_coord;
         value_ff <= req_value_bits;
      end
   end

   scr_addr u_addr (
      .clock       (clock),
      .outer_coord (outer_ff),
      .position    (pos_ff),
      .inner_coord (inner_ff),
      .dim_size    (dim_ff),
      .inner_size  (inner_size_ff),
      .result      (ares)
   );

   assign flat40  = {28'b0, flat_ff};
   assign flat_ok = flat40 < DEPTH40;
   assign addr_ok = ares.addr < DEPTH40;
   assign sel40   = (act_ff == ACT_SCATTER) ? ares.addr : flat40;

   scr_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sel40[AW-1:0]),
      .wr_data (res_bits),
      .rd_en   (state_ff == S_READ),
      .rd_addr (sel40[AW-1:0]),
      .rd_data (rd_data)
   );

   scr_fpu u_fpu (
      .clock  (clock),
      .mode   (mode_ff),
      .d_bits (rd_data),
      .s_bits (value_ff),
      .r_bits (comb_bits)
   );

   always_comb begin
      res_bits   = 32'b0;
      res_status = STAT_DONE;
      case (act_ff)
         ACT_WRITE: begin
            if (flat_ok) begin
               res_bits = value_ff;
            end else begin
               res_status = STAT_BEYOND;
            end
         end
         ACT_READ: begin
            if (flat_ok) begin
               res_bits = rd_data;
            end else begin
               res_status = STAT_BEYOND;
            end
         end
         ACT_SCATTER: begin
            if (ares.pos_bad) begin
               res_status = STAT_SKIP;
            end else if (addr_ok) begin
               res_bits = comb_bits;
            end else begin
               res_status = STAT_BEYOND;
            end
         end
         default: ;
      endcase
   end

   assign finish = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign wr_en  = finish && (((act_ff == ACT_WRITE) && flat_ok) ||
                   ((act_ff == ACT_SCATTER) && !ares.pos_bad && addr_ok));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_ADDR;
               cnt_in   = 3'd0;
            end
         end
         S_ADDR: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(ADDR_LATENCY - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_COMB;
            cnt_in   = 3'd0;
         end
         S_COMB: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(FPU_LATENCY - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_bits_ff   <= res_bits;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_bits = rsp_bits_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the scatter-reduce store: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
   import scr_pkg::*;

   // action and mode codes that the block treats as undefined
   localparam logic [1:0] ACT_UNDEF  = 2'd3;
   localparam logic [2:0] MODE_SPARE = 3'd7;

   typedef struct {
      logic [1:0]         action;
      logic [11:0]        flat;
      logic [11:0]        outer;
      logic signed [15:0] pos;
      logic [11:0]        inner;
      logic [31:0]        value;
   } request_type;

   typedef struct {
      logic [31:0] bits;
      logic [1:0]  status;
      bit          any_nan;
   } word_result_type;

   typedef enum bit {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [1:0]      csr_idx;
      logic [12:0]     csr_val;
      request_type     req;
      bit              typed;
      word_result_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = '0;
   logic [11:0]        req_flat_address = '0;
   logic [11:0]        req_outer_coord = '0;
   logic signed [15:0] req_position = '0;
   logic [11:0]        req_inner_coord = '0;
   logic [31:0]        req_value_bits = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_read_bits;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [12:0]        csr_data = '0;

   scatter_reduce_store uut (.*);

   always #1 clock = ~clock;

   // shadow of the block
   logic [31:0]  shadow_store [STORE_DEPTH_DEFAULT];
   bit           shadow_written [STORE_DEPTH_DEFAULT];
   bit           shadow_loose_nan [STORE_DEPTH_DEFAULT];
   logic [11:0]  written_addrs [$];
   logic [2:0]   cur_mode = MODE_ASSIGN;
   logic [12:0]  cur_dim = 13'd1;
   logic [12:0]  cur_inner = 13'd1;

   word_result_type pending_results [$];
   int              errors = 0;
   int              n_requests = 0;
   int              n_results = 0;
   int              n_csr = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              stall_hold = 0;
   bit              long_hold_req = 1'b0;
   bit              long_hold_taken = 1'b0;
   stim_row_type    directed [$];

   function automatic bit is_nan(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 0;
   endfunction

   function automatic real fp32_to_real(logic [31:0] b);
      bit [63:0] d;
      bit [22:0] m;
      int        sh;
      m = b[22:0];
      sh = 0;
      if (b[30:23] == 8'hFF) begin
         d = {b[31], 11'h7FF, m, 29'b0};
      end else if (b[30:23] == 0) begin
         if (m == 0) begin
            d = {b[31], 63'b0};
         end else begin
            while (!m[22]) begin
               m = m << 1;
               sh++;
            end
            m = m << 1;
            d = {b[31], 11'(896 - sh), m, 29'b0};
         end
      end else begin
         d = {b[31], 11'(int'(b[30:23]) + 896), m, 29'b0};
      end
      return $bitstoreal(d);
   endfunction

   // round a double to single, nearest-even, with subnormals
   function automatic logic [31:0] real_to_fp32(real r);
      bit [63:0] d;
      bit        s;
      int        ue, sh;
      bit [63:0] sig, q, rem, half;
      longint    t;
      d = $realtobits(r);
      s = d[63];
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? {s, 31'h7FC0_0000} : {s, 8'hFF, 23'b0};
      if (d[62:52] == 0)
         return {s, 31'b0};
      ue = int'(d[62:52]) - 1023;
      sig = {11'b0, 1'b1, d[51:0]};
      sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
      if (sh > 60)
         return {s, 31'b0};
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0]))
         q++;
      if (ue >= -126)
         t = (longint'(ue + 126) << 23) + longint'(q);
      else
         t = longint'(q);
      if (t >= 64'h7F80_0000)
         return {s, 8'hFF, 23'b0};
      return {s, t[30:0]};
   endfunction

   function automatic longint unsigned scatter_addr(request_type r);
      return (longint'(r.outer) * cur_dim + longint'(r.pos)) * cur_inner + r.inner;
   endfunction

   function automatic bit pos_skipped(request_type r);
      return r.pos < 0 || 32'(r.pos) >= 32'(cur_dim);
   endfunction

   // advance the shadow store by one request and give its result
   function automatic word_result_type apply_request(request_type r);
      word_result_type w;
      longint unsigned a;
      real             dv, sv;
      logic [31:0]     dbits;
      bit              dloose;
      w = '{32'd0, STAT_DONE, 1'b0};
      case (r.action)
         ACT_WRITE: begin
            shadow_store[r.flat] = r.value;
            shadow_loose_nan[r.flat] = 1'b0;
            w.bits = r.value;
         end
         ACT_READ: begin
            w.bits = shadow_store[r.flat];
            w.any_nan = shadow_loose_nan[r.flat];
         end
         ACT_SCATTER: begin
            a = scatter_addr(r);
            if (pos_skipped(r)) begin
               w.status = STAT_SKIP;
            end else if (a >= STORE_DEPTH_DEFAULT) begin
               w.status = STAT_BEYOND;
            end else begin
               dbits = shadow_store[a];
               dloose = shadow_loose_nan[a];
               dv = fp32_to_real(dbits);
               sv = fp32_to_real(r.value);
               case (cur_mode)
                  MODE_ADD: begin
                     w.bits = real_to_fp32(dv + sv);
                     w.any_nan = is_nan(w.bits);
                  end
                  MODE_MUL: begin
                     w.bits = real_to_fp32(dv * sv);
                     w.any_nan = is_nan(w.bits);
                  end
                  MODE_MAX: begin
                     w.bits = (dv < sv) ? r.value : dbits;
                     w.any_nan = (dv < sv) ? 1'b0 : dloose;
                  end
                  MODE_MIN: begin
                     w.bits = (sv < dv) ? r.value : dbits;
                     w.any_nan = (sv < dv) ? 1'b0 : dloose;
                  end
                  default: w.bits = r.value;
               endcase
               shadow_store[a] = w.bits;
               shadow_loose_nan[a] = w.any_nan;
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] MISMATCH %s: got %h expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      word_result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_read_bits, 32'd0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_status !== w.status)
               report_mismatch("status", 32'(rsp_status), 32'(w.status));
            if (w.any_nan ? !is_nan(rsp_read_bits) : rsp_read_bits !== w.bits)
               report_mismatch("read_bits", rsp_read_bits, w.bits);
         end
      end
   end

   // result-side back pressure; one long hold on request
   always @(negedge clock) begin
      if (long_hold_req && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         stall_hold <= 299;
         rsp_stall <= 1'b1;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_request(request_type r, bit typed, word_result_type want);
      word_result_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_action <= r.action;
      req_flat_address <= r.flat;
      req_outer_coord <= r.outer;
      req_position <= r.pos;
      req_inner_coord <= r.inner;
      req_value_bits <= r.value;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      w = apply_request(r);
      pending_results = {pending_results, (typed ? want : w)};
      n_requests++;
      if (r.action == ACT_WRITE && !shadow_written[r.flat]) begin
         shadow_written[r.flat] = 1'b1;
         written_addrs = {written_addrs, r.flat};
      end
      if (r.action == ACT_SCATTER && !pos_skipped(r) && scatter_addr(r) < STORE_DEPTH_DEFAULT
          && !shadow_written[scatter_addr(r)]) begin
         shadow_written[scatter_addr(r)] = 1'b1;
         written_addrs = {written_addrs, 12'(scatter_addr(r))};
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_MODE:  cur_mode = val[2:0];
         CSR_DIM:   cur_dim = val;
         CSR_INNER: cur_inner = val;
         default: ;
      endcase
      n_csr++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {1'($urandom_range(1)), 8'hFF, 23'b0};
         3: return 32'h7FC0_0000 | ($urandom & 32'h803F_FFFF);
         4: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
         5: return {1'($urandom_range(1)), 8'(7'h3F + $urandom_range(2)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // random request, steered away from entries that were never written
   function automatic request_type random_request();
      request_type     r;
      int              k, cap;
      longint unsigned a;
      k = $urandom_range(99);
      r.action = (k < 20) ? ACT_WRITE : (k < 75) ? ACT_SCATTER : (k < 95) ? ACT_READ : ACT_UNDEF;
      r.value = pick_value();
      if (written_addrs.size() > 0 && $urandom_range(9) < 7)
         r.flat = written_addrs[$urandom_range(written_addrs.size() - 1)];
      else
         r.flat = $urandom_range(9) < 8 ? 12'($urandom_range(255)) : 12'($urandom);
      cap = 4096 / (int'(cur_dim) * int'(cur_inner));
      r.outer = ($urandom_range(9) == 0 || cap == 0) ? 12'($urandom)
                : 12'($urandom_range(cap - 1));
      k = $urandom_range(9);
      if (k == 0)
         r.pos = -16'sd1 - 16'($urandom_range(32767));
      else if (k == 1)
         r.pos = 16'(int'(cur_dim) + $urandom_range(32767 - int'(cur_dim)));
      else
         r.pos = 16'($urandom_range(int'(cur_dim) - 1));
      r.inner = ($urandom_range(9) == 0) ? 12'($urandom)
                : 12'($urandom_range(int'(cur_inner) - 1));
      if (r.action == ACT_READ && !shadow_written[r.flat])
         r.action = ACT_WRITE;
      if (r.action == ACT_SCATTER && !pos_skipped(r)) begin
         a = scatter_addr(r);
         if (a < STORE_DEPTH_DEFAULT && !shadow_written[a]
             && cur_mode inside {[MODE_ADD:MODE_MIN]}) begin
            r.action = ACT_WRITE;
            r.flat = 12'(a);
         end
      end
      return r;
   endfunction

   function automatic stim_row_type req_row(logic [1:0] act, logic [11:0] flat,
                                            logic [11:0] outer, logic signed [15:0] pos,
                                            logic [11:0] inner, logic [31:0] value,
                                            bit typed = 0, logic [31:0] bits = 0,
                                            logic [1:0] st = STAT_DONE);
      stim_row_type row;
      row.kind = ROW_REQUEST;
      row.csr_idx = CSR_MODE;
      row.csr_val = '0;
      row.req = '{act, flat, outer, pos, inner, value};
      row.typed = typed;
      row.want = '{bits, st, 1'b0};
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [1:0] idx, logic [12:0] val);
      stim_row_type row;
      row = req_row(ACT_WRITE, 0, 0, 0, 0, 0);
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   function automatic void add_row(stim_row_type row);
      directed = {directed, row};
   endfunction

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      request_type     r;
      word_result_type none;
      int              phase, i;
      none = '{32'd0, STAT_DONE, 1'b0};
      for (i = 0; i < STORE_DEPTH_DEFAULT; i++) begin
         shadow_store[i] = '0;
         shadow_written[i] = 1'b0;
         shadow_loose_nan[i] = 1'b0;
      end

      // reset defaults: assign, dim 1, inner 1
      add_row(req_row(ACT_WRITE, 0, 0, 0, 0, 32'h3F80_0000, 1, 32'h3F80_0000));
      add_row(req_row(ACT_WRITE, 12'hFFF, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
      add_row(req_row(ACT_READ, 12'hFFF, 0, 0, 0, 0, 1, 32'hFFFF_FFFF));
      add_row(req_row(ACT_READ, 0, 0, 0, 0, 0, 1, 32'h3F80_0000));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 0, 32'h4000_0000, 1, 32'h4000_0000));
      add_row(req_row(ACT_SCATTER, 0, 0, 16'sh8000, 0, 32'h1234_5678, 1, 0, STAT_SKIP));
      add_row(req_row(ACT_SCATTER, 0, 0, 16'sh7FFF, 0, 32'h1234_5678, 1, 0, STAT_SKIP));
      add_row(req_row(ACT_SCATTER, 0, 0, 16'sd1, 0, 32'h1234_5678, 1, 0, STAT_SKIP));
      add_row(req_row(ACT_SCATTER, 0, 12'hFFF, 0, 0, 32'h0, 1, 32'h0));
      add_row(req_row(ACT_SCATTER, 0, 12'hFFF, 0, 12'hFFF, 32'h1, 1, 0, STAT_BEYOND));
      add_row(req_row(ACT_UNDEF, 12'hABC, 12'h123, 16'sd5, 12'h456, 32'hDEAD_BEEF,
                      1, 0, STAT_DONE));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 12'd5, 32'h7F80_0000, 1, 32'h7F80_0000));
      add_row(csr_row(CSR_MODE, 13'(MODE_ADD)));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 0, 32'h3F80_0000));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 12'd5, 32'hFF80_0000));
      add_row(csr_row(CSR_MODE, 13'(MODE_MUL)));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 0, 32'h0000_0001));
      add_row(csr_row(CSR_MODE, 13'(MODE_MAX)));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 0, 32'h7FC0_0000));
      add_row(req_row(ACT_SCATTER, 0, 12'hFFF, 0, 0, 32'h8000_0000));
      add_row(csr_row(CSR_MODE, 13'(MODE_MIN)));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 0, 32'hFF80_0000));
      add_row(csr_row(CSR_DIM, 13'd4096));
      add_row(csr_row(CSR_INNER, 13'd4096));
      add_row(csr_row(CSR_MODE, 13'(MODE_SPARE)));
      add_row(req_row(ACT_SCATTER, 0, 0, 0, 12'hFFF, 32'h4049_0FDB));
      add_row(req_row(ACT_SCATTER, 0, 0, 16'sd1, 0, 32'h1, 1, 0, STAT_BEYOND));
      add_row(req_row(ACT_SCATTER, 0, 0, 16'sd4096, 0, 32'h1, 1, 0, STAT_SKIP));

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[j]) begin
         if (directed[j].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed[j].csr_idx, directed[j].csr_val);
         end else begin
            send_request(directed[j].req, directed[j].typed, directed[j].want);
         end
      end

      for (phase = 0; phase < 8; phase++) begin
         wait_drained();
         write_csr(CSR_MODE, (phase < 5) ? 13'(phase) : 13'($urandom_range(7)));
         write_csr(CSR_DIM, phase == 1 ? 13'd4096 : phase == 0 || phase == 2 ? 13'd1
                            : 13'($urandom_range(1, 16)));
         write_csr(CSR_INNER, phase == 2 ? 13'd4096 : phase < 2 ? 13'd1
                              : 13'($urandom_range(1, 16)));
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         if (phase == 3)
            long_hold_req = 1'b1;
         for (i = 0; i < 210; i++) begin
            if (phase == 5 && i == 100)
               wait_drained();
            r = random_request();
            send_request(r, 1'b0, none);
         end
      end

      wait_drained();
      $display("Run covered %0d requests, %0d results and %0d register writes", n_requests,
               n_results, n_csr);
      $display("across all reduce modes, range extremes, skipped and out-of-store scatters.");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
